@@ hw/rtl/hmlc_pkg.sv @@
// Shared types and constants of the hue majority lamp classifier.
package hmlc_pkg;

	localparam int unsigned HUE_BITS  = 8;
	localparam int unsigned VAL_BITS  = 8;
	localparam int unsigned DEG_BITS  = 9;
	localparam int unsigned CIDX_BITS = 3;
	localparam int unsigned CODE_BITS = 3;

	// configuration register indexes
	localparam logic [CIDX_BITS-1:0] CFG_RED_LOW     = 3'd0;
	localparam logic [CIDX_BITS-1:0] CFG_RED_HIGH    = 3'd1;
	localparam logic [CIDX_BITS-1:0] CFG_YELLOW_LOW  = 3'd2;
	localparam logic [CIDX_BITS-1:0] CFG_YELLOW_HIGH = 3'd3;
	localparam logic [CIDX_BITS-1:0] CFG_GREEN_LOW   = 3'd4;
	localparam logic [CIDX_BITS-1:0] CFG_GREEN_HIGH  = 3'd5;

	// inclusive hue band in degrees; wraps through 360 when lo > hi
	typedef struct packed {
		logic [DEG_BITS-1:0] lo;
		logic [DEG_BITS-1:0] hi;
	} band_t;

endpackage

@@ hw/rtl/hmlc_band.sv @@
// Hue band membership test with wraparound.
module hmlc_band (
	input  hmlc_pkg::band_t                band,
	input  logic [hmlc_pkg::DEG_BITS-1:0]  deg,
	output logic                           hit
);

	logic ge_lo;
	logic le_hi;

	assign ge_lo = (deg >= band.lo);
	assign le_hi = (deg <= band.hi);
	assign hit   = (band.lo <= band.hi) ? (ge_lo && le_hi) : (ge_lo || le_hi);

endmodule

@@ hw/rtl/hmlc_tally.sv @@
// Saturating region counter, cleared after the region's last pixel.
module hmlc_tally #(
	parameter int unsigned COUNT_BITS = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  inc,
	input  logic                  clr,
	output logic [COUNT_BITS-1:0] cnt,
	output logic [COUNT_BITS-1:0] cnt_next
);

	logic [COUNT_BITS-1:0] cnt_q;

	// count including the pixel now in the stage
	assign cnt_next = (inc && (cnt_q != {COUNT_BITS{1'b1}})) ? cnt_q + COUNT_BITS'(1) : cnt_q;
	assign cnt      = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (en) begin
			cnt_q <= clr ? '0 : cnt_next;
		end
	end

endmodule

@@ hw/rtl/hue_majority_lamp_classifier_core.sv @@
// Top level of the hue majority lamp classifier.
//
// channel | signals                                           | direction
// --------+---------------------------------------------------+----------
// in      | in_valid/in_ready, hue_raw, brightness, last_pixel | sink
// out     | out_valid/out_ready, red_on, yellow_on, green_on,  | source
//         | lights_code                                       |
// cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data           | sink
//
// One pixel per cycle unless a last pixel stalls. A pixel goes into the input
// register (s1); band compare, counter update and majority compare run from s1
// into the counters and the result register, which a region result enters when
// its last pixel leaves s1.
// Reset clears counters, bounds and all valid flags. Only a last pixel
// waiting on a full result register stalls; other pixels keep flowing.
// cfg_ready is always high.
module hue_majority_lamp_classifier_core #(
	parameter int unsigned COUNT_BITS = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// pixel input
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [hmlc_pkg::HUE_BITS-1:0]       hue_raw,
	input  logic [hmlc_pkg::VAL_BITS-1:0]       brightness,
	input  logic                                last_pixel,
	// region result
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                red_on,
	output logic                                yellow_on,
	output logic                                green_on,
	output logic [hmlc_pkg::CODE_BITS-1:0]      lights_code,
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [hmlc_pkg::CIDX_BITS-1:0]      cfg_index,
	input  logic [hmlc_pkg::DEG_BITS-1:0]       cfg_data
);

	// hue band registers
	hmlc_pkg::band_t red_band_q, yellow_band_q, green_band_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_band_q    <= '0;
			yellow_band_q <= '0;
			green_band_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				hmlc_pkg::CFG_RED_LOW:     red_band_q.lo    <= cfg_data;
				hmlc_pkg::CFG_RED_HIGH:    red_band_q.hi    <= cfg_data;
				hmlc_pkg::CFG_YELLOW_LOW:  yellow_band_q.lo <= cfg_data;
				hmlc_pkg::CFG_YELLOW_HIGH: yellow_band_q.hi <= cfg_data;
				hmlc_pkg::CFG_GREEN_LOW:   green_band_q.lo  <= cfg_data;
				hmlc_pkg::CFG_GREEN_HIGH:  green_band_q.hi  <= cfg_data;
				default: ; // unknown index: dropped
			endcase
		end
	end

	// stage 1: registered input transaction
	logic                              vld_s1;
	logic [hmlc_pkg::HUE_BITS-1:0]     hue_s1;
	logic                              pix_s1;
	logic                              last_s1;

	logic out_valid_q;
	logic adv1;

	// s1 only holds when it carries a last pixel and the result slot is busy
	assign adv1     = vld_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !vld_s1 || adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			hue_s1  <= hue_raw;
			pix_s1  <= (brightness != '0);
			last_s1 <= last_pixel;
		end
	end

	// hue doubled into degrees (raw values above 179 are kept as is)
	logic [hmlc_pkg::DEG_BITS-1:0] deg_s1;
	logic red_hit, yellow_hit, green_hit;

	assign deg_s1 = {hue_s1, 1'b0};

	hmlc_band u_red_band    (.band(red_band_q),    .deg(deg_s1), .hit(red_hit));
	hmlc_band u_yellow_band (.band(yellow_band_q), .deg(deg_s1), .hit(yellow_hit));
	hmlc_band u_green_band  (.band(green_band_q),  .deg(deg_s1), .hit(green_hit));

	// region counters; cleared when the last pixel leaves s1
	logic [COUNT_BITS-1:0] valid_cnt, red_cnt, yellow_cnt, green_cnt;
	logic [COUNT_BITS-1:0] valid_nxt, red_nxt, yellow_nxt, green_nxt;

	hmlc_tally #(.COUNT_BITS(COUNT_BITS)) u_valid_tally (
		.clk(clk), .arst_n(arst_n), .en(adv1), .inc(pix_s1), .clr(last_s1),
		.cnt(valid_cnt), .cnt_next(valid_nxt));
	hmlc_tally #(.COUNT_BITS(COUNT_BITS)) u_red_tally (
		.clk(clk), .arst_n(arst_n), .en(adv1), .inc(pix_s1 && red_hit), .clr(last_s1),
		.cnt(red_cnt), .cnt_next(red_nxt));
	hmlc_tally #(.COUNT_BITS(COUNT_BITS)) u_yellow_tally (
		.clk(clk), .arst_n(arst_n), .en(adv1), .inc(pix_s1 && yellow_hit), .clr(last_s1),
		.cnt(yellow_cnt), .cnt_next(yellow_nxt));
	hmlc_tally #(.COUNT_BITS(COUNT_BITS)) u_green_tally (
		.clk(clk), .arst_n(arst_n), .en(adv1), .inc(pix_s1 && green_hit), .clr(last_s1),
		.cnt(green_cnt), .cnt_next(green_nxt));

	// strict majority: 2 * count > valid, one bit wider to avoid overflow
	logic red_maj, yellow_maj, green_maj;
	assign red_maj    = {red_nxt, 1'b0}    > {1'b0, valid_nxt};
	assign yellow_maj = {yellow_nxt, 1'b0} > {1'b0, valid_nxt};
	assign green_maj  = {green_nxt, 1'b0}  > {1'b0, valid_nxt};

	logic red_q, yellow_q, green_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && last_s1) begin
			red_q    <= red_maj;
			yellow_q <= yellow_maj;
			green_q  <= green_maj;
		end
	end

	assign out_valid   = out_valid_q;
	assign red_on      = red_q;
	assign yellow_on   = yellow_q;
	assign green_on    = green_q;
	assign lights_code = {green_q, yellow_q, red_q};

	// a color count can never pass the valid count
	assert property (@(posedge clk) disable iff (!arst_n)
		(red_cnt <= valid_cnt) && (yellow_cnt <= valid_cnt) && (green_cnt <= valid_cnt))
		else $error("color count exceeds valid count");

	// the valid counter is empty right after a region result is loaded
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv1 && last_s1) |=> (valid_cnt == '0))
		else $error("counters not cleared after region end");

	// input only stalls when stage 1 holds a blocked transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (vld_s1 && last_s1 && out_valid_q))
		else $error("input stalled without a blocked region result");

endmodule
